// ===== hdl/sorted_hash_index_range_lookup_defines.svh =====
// assertion macros for the sorted hash index range lookup block
// used by the port checker; expects i_clk and i_rst_n in scope
`ifndef SORTED_HASH_INDEX_RANGE_LOOKUP_DEFINES_SVH
`define SORTED_HASH_INDEX_RANGE_LOOKUP_DEFINES_SVH

// property must hold at every clock edge outside reset
`define SHRIL_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// condition must never be seen outside reset
`define SHRIL_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(expr)) else $error(msg);

`endif

// ===== hdl/shril_pkg.sv =====
// shared types and constants for the sorted hash index range lookup block
// no dependencies; used by the controller, datapath, top level and checker
package shril_pkg;

    localparam int DEPTH = 64;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int HW    = 32;
    localparam int OW    = 32;
    localparam int POS_W = 6;

    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_INSERT = 2'd1;
    localparam logic [1:0] CMD_LOOKUP = 2'd2;

    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_MISS = 2'd1;
    localparam logic [1:0] STAT_FULL = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_PROBE,
        S_CMP,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_CHK,
        S_LOOK,
        S_HIT_LAST,
        S_MISS,
        S_FULL,
        S_CLR,
        S_INS_RES
    } t_state;

    typedef enum logic [1:0] {
        RD_MID,
        RD_LO,
        RD_LO_NEXT,
        RD_SHIFT
    } t_rd_sel;

    typedef enum logic [2:0] {
        RES_CLR,
        RES_INS,
        RES_MISS,
        RES_FULL,
        RES_HIT
    } t_res;

    typedef struct packed {
        logic    cap;
        logic    clr;
        logic    s_init;
        logic    s_upd;
        logic    rd_en;
        t_rd_sel rd_sel;
        logic    sh_init;
        logic    sh_wr;
        logic    ins_wr;
        logic    hold;
        logic    lo_inc;
        logic    emit;
        t_res    res;
        logic    last;
    } t_dp_cmd;

    typedef struct packed {
        logic [1:0] cmd;
        logic       lo_lt_hi;
        logic       full;
        logic       at_end;
        logic       nxt_end;
        logic       eq;
        logic       out_free;
    } t_dp_sts;

endpackage

// ===== hdl/shril_ram.sv =====
// generic single write port, single read port ram with registered read
// no dependencies
module shril_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic                                  i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/shril_datapath.sv =====
// datapath: request capture, search bounds, entry count, table ram, result register
// depends on shril_pkg and shril_ram
module shril_datapath (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic [1:0]              i_cmd,
    input  logic [31:0]             i_key_hash,
    input  logic [31:0]             i_record_offset,
    input  shril_pkg::t_dp_cmd      i_ctl,
    output shril_pkg::t_dp_sts      o_sts,
    input  logic                    i_stall,
    output logic                    o_valid,
    output logic [1:0]              o_status,
    output logic [31:0]             o_found_offset,
    output logic [5:0]              o_position,
    output logic                    o_last
);

    localparam int AW = shril_pkg::AW;
    localparam int CW = shril_pkg::CW;
    localparam int HW = shril_pkg::HW;
    localparam int OW = shril_pkg::OW;

    logic [1:0]           r_cmd;
    logic [HW-1:0]        r_key;
    logic [OW-1:0]        r_off;
    logic [CW-1:0]        r_count, n_count;
    logic [CW-1:0]        r_lo, n_lo;
    logic [CW-1:0]        r_hi, n_hi;
    logic [OW-1:0]        r_cur_off;
    logic                 r_out_valid, n_out_valid;
    logic [1:0]           r_out_status;
    logic [OW-1:0]        r_out_off;
    logic [shril_pkg::POS_W-1:0] r_out_pos;
    logic                 r_out_last;

    logic [CW:0]          w_sum;
    logic [AW-1:0]        w_mid;
    logic [CW-1:0]        w_lo_inc;
    logic [CW-1:0]        w_hi_dec;
    logic [HW+OW-1:0]     w_rdata;
    logic [HW-1:0]        w_rd_hash;
    logic                 w_go_right;
    logic                 w_we;
    logic [AW-1:0]        w_waddr;
    logic [HW+OW-1:0]     w_wdata;
    logic [AW-1:0]        w_raddr;

    assign w_sum     = {1'b0, r_lo} + {1'b0, r_hi};
    assign w_mid     = w_sum[AW:1];
    assign w_lo_inc  = r_lo + CW'(1);
    assign w_hi_dec  = r_hi - CW'(1);
    assign w_rd_hash = w_rdata[HW+OW-1:OW];

    // insert looks for the upper bound, lookup for the lower bound
    always_comb begin
        if (r_cmd == shril_pkg::CMD_INSERT) begin
            w_go_right = (w_rd_hash <= r_key);
        end else begin
            w_go_right = (w_rd_hash < r_key);
        end
    end

    always_comb begin
        case (i_ctl.rd_sel)
            shril_pkg::RD_MID:     w_raddr = w_mid;
            shril_pkg::RD_LO:      w_raddr = r_lo[AW-1:0];
            shril_pkg::RD_LO_NEXT: w_raddr = w_lo_inc[AW-1:0];
            shril_pkg::RD_SHIFT:   w_raddr = w_hi_dec[AW-1:0];
            default:               w_raddr = r_lo[AW-1:0];
        endcase
    end

    always_comb begin
        w_we    = i_ctl.sh_wr | i_ctl.ins_wr;
        w_waddr = r_hi[AW-1:0];
        w_wdata = w_rdata;
        if (i_ctl.ins_wr) begin
            w_waddr = r_lo[AW-1:0];
            w_wdata = {r_key, r_off};
        end
    end

    shril_ram #(
        .WIDTH(HW + OW),
        .DEPTH(shril_pkg::DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (i_ctl.rd_en),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_comb begin
        n_count = r_count;
        n_lo    = r_lo;
        n_hi    = r_hi;
        if (i_ctl.clr) begin
            n_count = '0;
        end
        if (i_ctl.ins_wr) begin
            n_count = r_count + CW'(1);
        end
        if (i_ctl.s_init) begin
            n_lo = '0;
            n_hi = r_count;
        end
        if (i_ctl.sh_init) begin
            n_hi = r_count;
        end
        if (i_ctl.s_upd) begin
            if (w_go_right) begin
                n_lo = CW'(w_mid) + CW'(1);
            end else begin
                n_hi = CW'(w_mid);
            end
        end
        if (i_ctl.sh_wr) begin
            n_hi = w_hi_dec;
        end
        if (i_ctl.lo_inc) begin
            n_lo = w_lo_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo <= n_lo;
        r_hi <= n_hi;
        if (i_ctl.cap) begin
            r_cmd <= i_cmd;
            r_key <= i_key_hash;
            r_off <= i_record_offset;
        end
        if (i_ctl.hold) begin
            r_cur_off <= w_rdata[OW-1:0];
        end
    end

    // result register
    always_comb begin
        n_out_valid = r_out_valid & i_stall;
        if (i_ctl.emit) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.emit) begin
            r_out_last <= i_ctl.last;
            case (i_ctl.res)
                shril_pkg::RES_CLR: begin
                    r_out_status <= shril_pkg::STAT_OK;
                    r_out_off    <= '0;
                    r_out_pos    <= '0;
                end
                shril_pkg::RES_INS: begin
                    r_out_status <= shril_pkg::STAT_OK;
                    r_out_off    <= '0;
                    r_out_pos    <= shril_pkg::POS_W'(r_lo);
                end
                shril_pkg::RES_MISS: begin
                    r_out_status <= shril_pkg::STAT_MISS;
                    r_out_off    <= '0;
                    r_out_pos    <= '0;
                end
                shril_pkg::RES_FULL: begin
                    r_out_status <= shril_pkg::STAT_FULL;
                    r_out_off    <= '0;
                    r_out_pos    <= '0;
                end
                shril_pkg::RES_HIT: begin
                    r_out_status <= shril_pkg::STAT_OK;
                    r_out_off    <= r_cur_off;
                    r_out_pos    <= shril_pkg::POS_W'(r_lo);
                end
                default: begin
                    r_out_status <= shril_pkg::STAT_MISS;
                    r_out_off    <= '0;
                    r_out_pos    <= '0;
                end
            endcase
        end
    end

    assign o_sts.cmd      = r_cmd;
    assign o_sts.lo_lt_hi = (r_lo < r_hi);
    assign o_sts.full     = (r_count >= CW'(shril_pkg::DEPTH));
    assign o_sts.at_end   = (r_lo >= r_count);
    assign o_sts.nxt_end  = (w_lo_inc >= r_count);
    assign o_sts.eq       = (w_rd_hash == r_key);
    assign o_sts.out_free = ~r_out_valid | ~i_stall;

    assign o_valid        = r_out_valid;
    assign o_status       = r_out_status;
    assign o_found_offset = r_out_off;
    assign o_position     = r_out_pos;
    assign o_last         = r_out_last;

endmodule

// ===== hdl/shril_ctrl.sv =====
// controller state machine: sequences search, shift, group scan and result issue
// depends on shril_pkg
module shril_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  shril_pkg::t_dp_sts  i_sts,
    output shril_pkg::t_dp_cmd  o_ctl
);

    shril_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= shril_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_ctl   = '0;
        o_ctl.rd_sel = shril_pkg::RD_LO;
        o_ctl.res    = shril_pkg::RES_MISS;
        o_stall = (r_state != shril_pkg::S_IDLE);
        case (r_state)
            shril_pkg::S_IDLE: begin
                if (i_valid) begin
                    o_ctl.cap = 1'b1;
                    n_state   = shril_pkg::S_DECODE;
                end
            end
            shril_pkg::S_DECODE: begin
                case (i_sts.cmd)
                    shril_pkg::CMD_CLEAR: begin
                        n_state = shril_pkg::S_CLR;
                    end
                    shril_pkg::CMD_INSERT: begin
                        if (i_sts.full) begin
                            n_state = shril_pkg::S_FULL;
                        end else begin
                            o_ctl.s_init = 1'b1;
                            n_state      = shril_pkg::S_PROBE;
                        end
                    end
                    shril_pkg::CMD_LOOKUP: begin
                        o_ctl.s_init = 1'b1;
                        n_state      = shril_pkg::S_PROBE;
                    end
                    default: begin
                        n_state = shril_pkg::S_IDLE;
                    end
                endcase
            end
            shril_pkg::S_PROBE: begin
                if (i_sts.lo_lt_hi) begin
                    o_ctl.rd_en  = 1'b1;
                    o_ctl.rd_sel = shril_pkg::RD_MID;
                    n_state      = shril_pkg::S_CMP;
                end else if (i_sts.cmd == shril_pkg::CMD_INSERT) begin
                    o_ctl.sh_init = 1'b1;
                    n_state       = shril_pkg::S_SHIFT_RD;
                end else if (i_sts.at_end) begin
                    n_state = shril_pkg::S_MISS;
                end else begin
                    o_ctl.rd_en  = 1'b1;
                    o_ctl.rd_sel = shril_pkg::RD_LO;
                    n_state      = shril_pkg::S_CHK;
                end
            end
            shril_pkg::S_CMP: begin
                o_ctl.s_upd = 1'b1;
                n_state     = shril_pkg::S_PROBE;
            end
            shril_pkg::S_SHIFT_RD: begin
                if (i_sts.lo_lt_hi) begin
                    o_ctl.rd_en  = 1'b1;
                    o_ctl.rd_sel = shril_pkg::RD_SHIFT;
                    n_state      = shril_pkg::S_SHIFT_WR;
                end else begin
                    o_ctl.ins_wr = 1'b1;
                    n_state      = shril_pkg::S_INS_RES;
                end
            end
            shril_pkg::S_SHIFT_WR: begin
                o_ctl.sh_wr = 1'b1;
                n_state     = shril_pkg::S_SHIFT_RD;
            end
            shril_pkg::S_CHK: begin
                if (!i_sts.eq) begin
                    n_state = shril_pkg::S_MISS;
                end else begin
                    o_ctl.hold = 1'b1;
                    if (i_sts.nxt_end) begin
                        n_state = shril_pkg::S_HIT_LAST;
                    end else begin
                        o_ctl.rd_en  = 1'b1;
                        o_ctl.rd_sel = shril_pkg::RD_LO_NEXT;
                        n_state      = shril_pkg::S_LOOK;
                    end
                end
            end
            shril_pkg::S_LOOK: begin
                if (i_sts.out_free) begin
                    o_ctl.emit = 1'b1;
                    o_ctl.res  = shril_pkg::RES_HIT;
                    o_ctl.last = ~i_sts.eq;
                    if (i_sts.eq) begin
                        o_ctl.lo_inc = 1'b1;
                        o_ctl.rd_en  = 1'b1;
                        o_ctl.rd_sel = shril_pkg::RD_LO_NEXT;
                        n_state      = shril_pkg::S_CHK;
                    end else begin
                        n_state = shril_pkg::S_IDLE;
                    end
                end
            end
            shril_pkg::S_HIT_LAST: begin
                if (i_sts.out_free) begin
                    o_ctl.emit = 1'b1;
                    o_ctl.res  = shril_pkg::RES_HIT;
                    o_ctl.last = 1'b1;
                    n_state    = shril_pkg::S_IDLE;
                end
            end
            shril_pkg::S_MISS: begin
                if (i_sts.out_free) begin
                    o_ctl.emit = 1'b1;
                    o_ctl.res  = shril_pkg::RES_MISS;
                    o_ctl.last = 1'b1;
                    n_state    = shril_pkg::S_IDLE;
                end
            end
            shril_pkg::S_FULL: begin
                if (i_sts.out_free) begin
                    o_ctl.emit = 1'b1;
                    o_ctl.res  = shril_pkg::RES_FULL;
                    o_ctl.last = 1'b1;
                    n_state    = shril_pkg::S_IDLE;
                end
            end
            shril_pkg::S_CLR: begin
                if (i_sts.out_free) begin
                    o_ctl.clr  = 1'b1;
                    o_ctl.emit = 1'b1;
                    o_ctl.res  = shril_pkg::RES_CLR;
                    o_ctl.last = 1'b1;
                    n_state    = shril_pkg::S_IDLE;
                end
            end
            shril_pkg::S_INS_RES: begin
                if (i_sts.out_free) begin
                    o_ctl.emit = 1'b1;
                    o_ctl.res  = shril_pkg::RES_INS;
                    o_ctl.last = 1'b1;
                    n_state    = shril_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = shril_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/sorted_hash_index_range_lookup.sv =====
// top level of the sorted hash index range lookup block
// depends on shril_pkg, shril_ctrl, shril_datapath and shril_ram
//
// keeps up to 64 records (32-bit key hash, 32-bit record offset) in one ram, sorted by
// ascending hash, equal hashes in arrival order. a clear request empties the table, an
// insert request places a record in sorted position (status table full when 64 are
// held), a lookup request returns every record of the matching hash group, one result
// each in table order with last set on the final one, or a single not-found result.
// requests are handled one at a time: o_stall is low only while the block is idle.
// the table ram gives one registered read per cycle, and a binary search probe is a
// read then a compare. a clear passes decode, then issues its result. an insert runs
// p probes (up to 6), moves s records up one place to open the slot (up to 63), each a
// read then a write, then writes the record. a lookup runs p probes, p up to 7, to its
// miss or first hit result, and reads and compares the next entry for each further one.
// each result sits in an output register until taken, so a stall on the result side
// only holds the sequencer at its next issue.
// the ram contents are undefined after reset; only entries below the entry count are
// ever read, so no clearing pass is needed.
module sorted_hash_index_range_lookup (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_cmd,
    input  logic [31:0] i_key_hash,
    input  logic [31:0] i_record_offset,
    // result channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_status,
    output logic [31:0] o_found_offset,
    output logic [5:0]  o_position,
    output logic        o_last
);

    // commands from the sequencer, status back from the datapath
    shril_pkg::t_dp_cmd w_ctl;
    shril_pkg::t_dp_sts w_sts;

    shril_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (w_sts),
        .o_ctl   (w_ctl)
    );

    // search bounds, entry count, table ram and result register
    shril_datapath u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (i_cmd),
        .i_key_hash      (i_key_hash),
        .i_record_offset (i_record_offset),
        .i_ctl           (w_ctl),
        .o_sts           (w_sts),
        .i_stall         (i_stall),
        .o_valid         (o_valid),
        .o_status        (o_status),
        .o_found_offset  (o_found_offset),
        .o_position      (o_position),
        .o_last          (o_last)
    );

endmodule

// ===== hdl/shril_checker.sv =====
// port level checker for the sorted hash index range lookup block, bound to the top
// depends on shril_pkg and sorted_hash_index_range_lookup_defines.svh
`include "sorted_hash_index_range_lookup_defines.svh"

module shril_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic [1:0]  i_cmd,
    input logic [31:0] i_key_hash,
    input logic [31:0] i_record_offset,
    input logic        o_valid,
    input logic        i_stall,
    input logic [1:0]  o_status,
    input logic [31:0] o_found_offset,
    input logic [5:0]  o_position,
    input logic        o_last
);

    // a stalled result keeps its payload
    `SHRIL_ASSERT(a_out_hold, ((o_valid && i_stall) |=> (o_valid && $stable(o_status) && $stable(o_found_offset) && $stable(o_position) && $stable(o_last))), "stalled result changed")

    // one request at a time: an accepted request closes the request channel
    `SHRIL_ASSERT(a_one_at_a_time, ((i_valid && !o_stall) |=> o_stall), "request accepted while busy")

    // a miss or a full table result is always the only one of its request
    `SHRIL_NEVER(a_err_last, (o_valid && (o_status != shril_pkg::STAT_OK) && !o_last), "error result not last")

    // error results carry no offset and no position
    `SHRIL_NEVER(a_err_zero, (o_valid && (o_status != shril_pkg::STAT_OK) && ((o_found_offset != 32'd0) || (o_position != 6'd0))), "error result not zero")

endmodule

bind sorted_hash_index_range_lookup shril_checker u_shril_checker (.*);
